// File: rtl/fir_pkg.sv
// shared types and constants for the circular-history fir filter
package fir_pkg;

  // item kinds carried on in_tuser
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_COEF    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_SAMPLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT   = 1'd1;

  // field widths
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned TAP_CNT_W   = 5;
  localparam int unsigned COEF_IDX_W  = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 16;

  // reset value of the tap count register
  localparam logic [TAP_CNT_W-1:0] TAP_COUNT_RST = 5'd16;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

endpackage

// File: rtl/fir_ram.sv
// generic single-write, single-read ram with registered read data
module fir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fir_filter_circular_history.sv
// fir filter over a circular sample history, one shared multiply-accumulate
//
//  channel | direction | handshake          | contents
//  in_     | slave     | in_tvalid/tready   | tuser kind, tdata sample/coef_index/coef_value
//  out_    | master    | out_tvalid/tready  | tdata filtered, tuser clipped
//  cfg_    | slave     | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// after a sample transfer the next input is taken only back in idle. with n the
// effective tap count, the walk does one read of history and coefficient ram per tap
// through the single multiplier, drains the registered ram read and the product
// register, rounds into the output register and returns to idle to take the next input.
// coefficient load, restart and unused kinds give no result and leave the sequencer idle.
// restart clears no ram: per-entry valid bits make unwritten history read the fill value.
// reset is synchronous active low; rams need no clearing pass.
// a full output register stalls only the final load of the next result.
module fir_filter_circular_history #(
  parameter int unsigned TAPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [15:0] sample, [19:16] coef_index, [35:20] coef_value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] filtered
  output logic        out_tuser,  // [0] clipped
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned AW    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int unsigned NW    = $clog2(TAPS + 1);
  localparam int unsigned ACCW  = 32 + $clog2(TAPS);
  localparam int unsigned RW    = ACCW + 1 - 15;
  localparam int unsigned DW    = fir_pkg::DATA_W;
  localparam logic signed [RW-1:0] SAT_MAX = RW'(32'sd32767);
  localparam logic signed [RW-1:0] SAT_MIN = RW'(-32'sd32768);
  localparam logic signed [ACCW:0] RND_BIAS = (ACCW+1)'(32'sd16384);

  // input field slices
  logic signed [DW-1:0]                 in_sample;
  logic [fir_pkg::COEF_IDX_W-1:0]       in_coef_index;
  logic signed [DW-1:0]                 in_coef_value;

  assign in_sample     = in_tdata[15:0];
  assign in_coef_index = in_tdata[19:16];
  assign in_coef_value = in_tdata[35:20];

  // configuration registers
  logic signed [DW-1:0]                 init_sample_r;
  logic [fir_pkg::TAP_CNT_W-1:0]        tap_count_r;

  // control state
  fir_pkg::state_t                      state_r, state_nxt;
  logic [AW-1:0]                        wp_r;
  logic [AW-1:0]                        pos_r;
  logic [AW-1:0]                        k_r;
  logic [NW-1:0]                        n_r;
  logic [TAPS-1:0]                      hv_r;
  logic [TAPS-1:0]                      cv_r;
  logic signed [DW-1:0]                 fill_r;
  logic                                 v1_r, v2_r;
  logic                                 hv_q_r, cv_q_r;
  logic signed [31:0]                   prod_r;
  logic signed [ACCW-1:0]               acc_r;
  logic                                 out_valid_r;
  logic [DW-1:0]                        out_data_r;
  logic                                 out_clip_r;

  // datapath wires
  logic [NW-1:0]                        n_eff;
  logic [AW-1:0]                        p_sel;
  logic [AW-1:0]                        n_last;
  logic                                 in_xfer;
  logic                                 out_load;
  logic                                 coef_we;
  logic [AW-1:0]                        coef_waddr;
  logic [DW-1:0]                        hist_rdata;
  logic [DW-1:0]                        coef_rdata;
  logic signed [DW-1:0]                 hist_val;
  logic signed [DW-1:0]                 coef_val;
  logic signed [ACCW:0]                 biased;
  logic signed [RW-1:0]                 rnd;
  logic [DW-1:0]                        sat_val;
  logic                                 sat_clip;

  assign in_tready  = (state_r == fir_pkg::S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

  // effective tap count and clamped write pointer
  always_comb begin
    if (tap_count_r == '0) begin
      n_eff = NW'(1);
    end else if (int'(tap_count_r) > int'(TAPS)) begin
      n_eff = NW'(TAPS);
    end else begin
      n_eff = NW'(tap_count_r);
    end
    p_sel  = (int'(wp_r) >= int'(n_eff)) ? '0 : wp_r;
    n_last = AW'(n_r - NW'(1));
  end

  // coefficient load decode
  assign coef_we    = in_xfer && (in_tuser == fir_pkg::KIND_COEF) &&
                      (int'(in_coef_index) < int'(TAPS));
  assign coef_waddr = AW'(int'(in_coef_index));

  fir_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_hist_ram (
    .clk   (clk),
    .we    (in_xfer && (in_tuser == fir_pkg::KIND_SAMPLE)),
    .waddr (p_sel),
    .wdata (in_sample),
    .raddr (pos_r),
    .rdata (hist_rdata)
  );

  fir_ram #(.WIDTH(DW), .DEPTH(TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (coef_waddr),
    .wdata (in_coef_value),
    .raddr (k_r),
    .rdata (coef_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_sample_r <= '0;
      tap_count_r   <= fir_pkg::TAP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        fir_pkg::REG_INIT_SAMPLE: init_sample_r <= cfg_data;
        fir_pkg::REG_TAP_COUNT:   tap_count_r   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fir_pkg::S_IDLE: begin
        if (in_xfer && (in_tuser == fir_pkg::KIND_SAMPLE)) begin
          state_nxt = fir_pkg::S_ISSUE;
        end
      end
      fir_pkg::S_ISSUE: begin
        if (k_r == n_last) begin
          state_nxt = fir_pkg::S_DRAIN;
        end
      end
      fir_pkg::S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          state_nxt = fir_pkg::S_DONE;
        end
      end
      fir_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = fir_pkg::S_IDLE;
        end
      end
      default: state_nxt = fir_pkg::S_IDLE;
    endcase
  end

  assign out_load = (state_r == fir_pkg::S_DONE) && (!out_valid_r || out_tready);

  // control registers: pointer, counters, valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fir_pkg::S_IDLE;
      wp_r    <= '0;
      pos_r   <= '0;
      k_r     <= '0;
      n_r     <= NW'(1);
      hv_r    <= '0;
      cv_r    <= '0;
      fill_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == fir_pkg::S_ISSUE);
      v2_r    <= v1_r;
      if (in_xfer) begin
        case (in_tuser)
          fir_pkg::KIND_SAMPLE: begin
            hv_r[p_sel] <= 1'b1;
            pos_r       <= p_sel;
            k_r         <= '0;
            n_r         <= n_eff;
            wp_r        <= (int'(p_sel) + 1 >= int'(n_eff)) ? '0 : AW'(p_sel + AW'(1));
          end
          fir_pkg::KIND_COEF: begin
            if (coef_we) begin
              cv_r[coef_waddr] <= 1'b1;
            end
          end
          fir_pkg::KIND_RESTART: begin
            hv_r   <= '0;
            fill_r <= init_sample_r;
            wp_r   <= '0;
          end
          default: ;
        endcase
      end else if (state_r == fir_pkg::S_ISSUE) begin
        // walk back through the ring, forward through the coefficients
        pos_r <= (pos_r == '0) ? n_last : AW'(pos_r - AW'(1));
        k_r   <= AW'(k_r + AW'(1));
      end
    end
  end

  // valid bits are registered in step with the ram read
  always_ff @(posedge clk) begin
    hv_q_r <= hv_r[pos_r];
    cv_q_r <= cv_r[k_r];
  end

  // unwritten entries read as fill value or zero
  assign hist_val = hv_q_r ? $signed(hist_rdata) : fill_r;
  assign coef_val = cv_q_r ? $signed(coef_rdata) : '0;

  // product and accumulate
  always_ff @(posedge clk) begin
    prod_r <= hist_val * coef_val;
    if (in_xfer) begin
      acc_r <= '0;
    end else if (v2_r) begin
      acc_r <= acc_r + ACCW'(prod_r);
    end
  end

  // round half up to q1.15 and saturate
  always_comb begin
    biased   = (ACCW+1)'(acc_r) + RND_BIAS;
    rnd      = RW'(biased >>> 15);
    sat_clip = 1'b0;
    sat_val  = rnd[DW-1:0];
    if (rnd > SAT_MAX) begin
      sat_val  = SAT_MAX[DW-1:0];
      sat_clip = 1'b1;
    end else if (rnd < SAT_MIN) begin
      sat_val  = SAT_MIN[DW-1:0];
      sat_clip = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= sat_val;
      out_clip_r <= sat_clip;
    end
  end

`ifndef SYNTHESIS
  // a sample transfer starts the tap walk
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == fir_pkg::KIND_SAMPLE) |=> state_r == fir_pkg::S_ISSUE)
    else $error("sample transfer did not start tap walk");

  // tap counter stays inside the ring
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fir_pkg::S_ISSUE |-> int'(k_r) < int'(n_r))
    else $error("tap counter beyond ring length");

  // pipeline is empty whenever a new item may come in
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fir_pkg::S_IDLE |-> !v1_r && !v2_r)
    else $error("mac pipeline busy while idle");

  // a finished result always reaches the output register
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r && state_r == fir_pkg::S_IDLE)
    else $error("result not presented after load");

  // write pointer never leaves the ring storage
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(wp_r) < int'(TAPS))
    else $error("write pointer out of range");
`endif

endmodule

// File: tb/fir_filter_circular_history_test.sv
// self-checking testbench for the circular-history fir filter
module fir_filter_circular_history_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          RING_DEPTH   = 16;
  localparam int          SETTLE_WAIT  = 32;
  localparam longint      CYCLE_LIMIT  = 600000;
  localparam logic [1:0]  KIND_UNUSED  = 2'd3;

  typedef struct packed {
    logic [15:0] filtered;
    logic        clipped;
  } fir_result_t;

  // clock, reset and block ports
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata   = '0;   // [15:0] sample, [19:16] coef_index, [35:20] coef_value
  logic [1:0]  in_tuser   = fir_pkg::KIND_SAMPLE;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // [15:0] filtered
  logic        out_tuser;         // [0] clipped
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic        cfg_index  = fir_pkg::REG_INIT_SAMPLE;
  logic [15:0] cfg_data   = '0;

  // predictor state
  logic signed [15:0] hist_ring [RING_DEPTH];
  logic signed [15:0] coef_mem  [RING_DEPTH];
  logic [3:0]         ring_ptr;
  logic signed [15:0] fill_value;
  logic [4:0]         tap_setting;

  fir_result_t pending_outputs [$];

  // bookkeeping
  int     error_count   = 0;
  int     items_sent    = 0;
  int     results_seen  = 0;
  int     clipped_seen  = 0;
  int     config_writes = 0;
  longint cycle_count   = 0;
  bit     in_idle_en    = 1'b0;
  bit     out_idle_en   = 1'b0;
  int     stall_left    = 0;

  fir_filter_circular_history #(.TAPS(RING_DEPTH)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outputs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $realtime, what);
    error_count++;
  endtask

  // mostly short gaps, now and then a long one
  function automatic int gap_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [39:0] pack_item(input logic [15:0] smp, input logic [3:0] idx,
                                            input logic [15:0] val);
    return {4'b0000, val, idx, smp};
  endfunction

  // q1.15 value: full range, small, or one of the corners
  function automatic logic [15:0] rand_q15();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 16'($urandom);
    if (pick < 8) return 16'($signed($urandom_range(0, 2048)) - 1024);
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  // predictor: apply one accepted item, queue the expected output of a sample
  function automatic void filter_predict(input logic [1:0] kind, input logic [39:0] data);
    int          taps;
    int          wr;
    longint      acc;
    longint      rnd;
    fir_result_t res;
    case (kind)
      fir_pkg::KIND_COEF: begin
        coef_mem[data[19:16]] = data[35:20];
      end
      fir_pkg::KIND_RESTART: begin
        for (int i = 0; i < RING_DEPTH; i++) hist_ring[i] = fill_value;
        ring_ptr = '0;
      end
      fir_pkg::KIND_SAMPLE: begin
        taps = (tap_setting == 0) ? 1 : (tap_setting > RING_DEPTH) ? RING_DEPTH : tap_setting;
        wr   = (ring_ptr >= taps) ? 0 : ring_ptr;
        hist_ring[wr] = data[15:0];
        acc = 0;
        for (int k = 0; k < taps; k++)
          acc += longint'(coef_mem[k]) * longint'(hist_ring[(wr + taps - k) % taps]);
        // round half up, then saturate
        rnd = (acc + 64'sd16384) >>> 15;
        res.clipped = 1'b1;
        if (rnd > 32767) rnd = 32767;
        else if (rnd < -32768) rnd = -32768;
        else res.clipped = 1'b0;
        res.filtered = 16'(rnd);
        pending_outputs.push_back(res);
        ring_ptr = 4'((wr + 1) % taps);
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    fir_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (out_tuser) clipped_seen++;
      if (pending_outputs.size() == 0) begin
        report_mismatch($sformatf("result %h/%b with nothing expected", out_tdata, out_tuser));
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata !== want.filtered)
          report_mismatch($sformatf("filtered got %h expected %h", out_tdata, want.filtered));
        if (out_tuser !== want.clipped)
          report_mismatch($sformatf("clipped got %b expected %b", out_tuser, want.clipped));
      end
    end
  end

  // result-side back pressure
  always @(posedge clk) begin
    if (out_idle_en && stall_left == 0 && $urandom_range(0, 99) < 25) stall_left = gap_length();
    if (out_idle_en && stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // one input transfer; valid stays high afterwards unless a gap follows
  task automatic send_item(input logic [1:0] kind, input logic [39:0] data);
    int gap;
    gap = (in_idle_en && $urandom_range(0, 99) < 30) ? gap_length() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    filter_predict(kind, data);
    items_sent++;
  endtask

  // random item, mostly samples; unused fields carry noise
  task automatic send_random_item();
    int          pick;
    logic [1:0]  kind;
    pick = $urandom_range(0, 99);
    if (pick < 70) kind = fir_pkg::KIND_SAMPLE;
    else if (pick < 88) kind = fir_pkg::KIND_COEF;
    else if (pick < 95) kind = fir_pkg::KIND_RESTART;
    else kind = KIND_UNUSED;
    send_item(kind, pack_item(rand_q15(), 4'($urandom), rand_q15()));
  endtask

  // drop valid and wait until the filter has gone quiet
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // write both registers back to back while idle
  task automatic set_config(input logic [15:0] init_word, input logic [15:0] taps_word);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= fir_pkg::REG_INIT_SAMPLE;
    cfg_data  <= init_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    fill_value = init_word;
    cfg_index <= fir_pkg::REG_TAP_COUNT;
    cfg_data  <= taps_word;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tap_setting = taps_word[4:0];
    cfg_valid <= 1'b0;
    config_writes += 2;
  endtask

  task automatic test_power_on_defaults();
    // zero coefficients after reset give zero output
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h7fff, 4'hf, 16'hffff));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h8000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(rand_q15(), 4'($urandom), rand_q15()));
  endtask

  task automatic test_directed_cases();
    // single tap: rounding at the half point and the upper saturation limit
    set_config(16'h8000, 16'd1);
    send_item(fir_pkg::KIND_COEF, pack_item(16'h0000, 4'h0, 16'h0001));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h4000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_COEF, pack_item(16'h0000, 4'h0, 16'hffff));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h4000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_COEF, pack_item(16'h0000, 4'h0, 16'h8000));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h8000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_COEF, pack_item(16'h0000, 4'hf, 16'h7fff));
    send_item(KIND_UNUSED, pack_item(16'hffff, 4'hf, 16'hffff));
    send_item(fir_pkg::KIND_RESTART, pack_item(16'h0000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h7fff, 4'h0, 16'h0000));
    // tap count zero acts as one tap
    set_config(16'h7fff, 16'd0);
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h1234, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_RESTART, pack_item(16'h0000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h8000, 4'h0, 16'h0000));
    // tap count above the table with junk in the upper data bits, restart fills all
    set_config(16'hffff, 16'hffff);
    send_item(fir_pkg::KIND_RESTART, pack_item(16'h0000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_COEF, pack_item(16'h0000, 4'h1, 16'h8000));
    for (int i = 0; i < 4; i++) begin
      send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h7fff, 4'h0, 16'h0000));
    end
    // pointer past the ring after the tap count is lowered
    set_config(16'h0100, 16'd3);
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'h2000, 4'h0, 16'h0000));
    send_item(fir_pkg::KIND_SAMPLE, pack_item(16'hc000, 4'h0, 16'h0000));
  endtask

  task automatic test_config_sweep();
    logic [15:0] init_word;
    logic [15:0] taps_word;
    for (int phase = 0; phase < 10; phase++) begin
      init_word = rand_q15();
      taps_word = 16'($urandom);
      case (phase)
        0: taps_word = 16'd1;
        1: taps_word = 16'd16;
        2: taps_word = 16'd2;
        3: taps_word[4:0] = 5'd17;
        4: taps_word[4:0] = 5'd0;
        default: ;
      endcase
      set_config(init_word, taps_word);
      // alternate stretches with and without idling
      in_idle_en  = phase[0];
      out_idle_en = phase[1] | phase[2];
      if ($urandom_range(0, 1)) begin
        send_item(fir_pkg::KIND_RESTART, pack_item(rand_q15(), 4'($urandom), rand_q15()));
      end
      for (int i = 0; i < 35; i++) send_random_item();
    end
  endtask

  task automatic test_random_stream();
    // long stream with idling on both sides, small tap counts more often
    for (int seg = 0; seg < 3; seg++) begin
      set_config(rand_q15(), (seg == 2) ? 16'd16 : 16'($urandom_range(1, 8)));
      in_idle_en  = 1'b1;
      out_idle_en = 1'b1;
      for (int i = 0; i < 100; i++) send_random_item();
    end
  endtask

  initial begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      hist_ring[i] = '0;
      coef_mem[i]  = '0;
    end
    ring_ptr    = '0;
    fill_value  = '0;
    tap_setting = fir_pkg::TAP_COUNT_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_defaults();
    test_directed_cases();
    test_config_sweep();
    test_random_stream();
    wait_idle();

    $display("covered %0d input transfers, %0d results checked (%0d saturated)",
             items_sent, results_seen, clipped_seen);
    $display("%0d register writes across tap counts 0 to 31, %0d mismatches",
             config_writes, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
